[rtl/stcm_pkg.sv]
// types and constants shared by the saturation / tone curve mapper
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package stcm_pkg;

  // gray weights and blend range
  localparam logic [7:0] GRAY_W_RED   = 8'd77;
  localparam logic [7:0] GRAY_W_GREEN = 8'd28;
  localparam logic [7:0] GRAY_W_BLUE  = 8'd151;
  localparam logic [8:0] FULL_VIVID   = 9'd256;

  // item operations
  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_PIXEL       = 1'b1
  } op_t;

  // tone curve modes
  typedef enum logic [1:0] {
    CURVE_NONE    = 2'd0,
    CURVE_SHARED  = 2'd1,
    CURVE_CHANNEL = 2'd2,
    CURVE_CHAINED = 2'd3
  } curve_mode_t;

  // configuration register indexes
  localparam logic [0:0] CFG_CURVE_MODE = 1'b0;
  localparam logic [0:0] CFG_VIVIDNESS  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [10:0] table_address;
    logic [7:0]  table_data;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } out_item_t;

  // table write travelling down the pipeline
  typedef struct packed {
    logic        en;
    logic [10:0] addr;
    logic [7:0]  data;
  } tbl_wr_t;

endpackage

[rtl/saturation_tone_curve_mapper_unit.sv]
// Saturation blend and tone curve mapper for RGBA pixels. One item, a pixel or a
// tone table byte write, is taken every cycle unless the input stalls; a pixel's
// result passes the gray, blend, page and curve registers and the output buffer
// before it shows; a table write gives no result. The pipeline is gray weighting,
// vividness blend, per-channel page lookup, shared curve lookup, then a two-entry
// output buffer; the input stalls only when that buffer holds two waiting results.
// The tone table is held as one copy per color lane (two private 256-byte pages plus
// a shared 256-byte curve) so every lane has its own read port each cycle; a write
// updates every copy at the stage that reads it, which keeps writes and reads in item
// order. There is no clearing pass: a table entry must be written before a pixel uses
// it. Configuration writes are always ready and are meant for an idle block.
`timescale 1ns / 1ps

module saturation_tone_curve_mapper_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stcm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stcm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [8:0]          cfg_data
);
  import stcm_pkg::*;

  curve_mode_t curve_mode_r;
  logic [8:0]  vividness_r;

  logic       v1_r, v2_r, v3_r, v4_r;
  logic       pix3_r, pix4_r;
  logic [7:0] alpha3_r, alpha4_r;

  logic       en;
  logic       full;
  logic       push;
  in_item_t   s2_item;
  tbl_wr_t    s2_wr;
  logic [7:0] lane_out [3];
  out_item_t  push_data;

  assign cfg_ready = 1'b1;
  assign en        = !full;
  assign in_stall  = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r <= CURVE_NONE;
      vividness_r  <= FULL_VIVID;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURVE_MODE: curve_mode_r <= curve_mode_t'(cfg_data[1:0]);
        CFG_VIVIDNESS:  vividness_r  <= cfg_data;
        default:        curve_mode_r <= curve_mode_r;
      endcase
    end
  end

  // item valid bits move with the whole pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix3_r   <= (s2_item.operation == OP_PIXEL);
      pix4_r   <= pix3_r;
      alpha3_r <= s2_item.alpha_in;
      alpha4_r <= alpha3_r;
    end
  end

  stcm_blend u_blend (
    .clk       (clk),
    .en        (en),
    .vividness (vividness_r),
    .item_i    (in_data),
    .item_o    (s2_item)
  );

  assign s2_wr.en   = v2_r && (s2_item.operation == OP_TABLE_WRITE);
  assign s2_wr.addr = s2_item.table_address;
  assign s2_wr.data = s2_item.table_data;

  stcm_lane #(.LaneIdx(0)) u_lane_red (
    .clk        (clk),
    .en         (en),
    .curve_mode (curve_mode_r),
    .wr         (s2_wr),
    .chan_in    (s2_item.red_in),
    .chan_out   (lane_out[0])
  );

  stcm_lane #(.LaneIdx(1)) u_lane_green (
    .clk        (clk),
    .en         (en),
    .curve_mode (curve_mode_r),
    .wr         (s2_wr),
    .chan_in    (s2_item.green_in),
    .chan_out   (lane_out[1])
  );

  stcm_lane #(.LaneIdx(2)) u_lane_blue (
    .clk        (clk),
    .en         (en),
    .curve_mode (curve_mode_r),
    .wr         (s2_wr),
    .chan_in    (s2_item.blue_in),
    .chan_out   (lane_out[2])
  );

  assign push_data.red_out   = lane_out[0];
  assign push_data.green_out = lane_out[1];
  assign push_data.blue_out  = lane_out[2];
  assign push_data.alpha_out = alpha4_r;

  assign push = en && v4_r && pix4_r;

  stcm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // input stalls only while results are waiting downstream
  a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // a frozen pipeline keeps its last stage
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v4_r) && $stable(alpha4_r) && $stable(pix4_r))
    else $error("pipeline moved while stalled");

  // a result only shows up after a pixel left the last stage
  a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(push))
    else $error("result appeared without a pixel item");

endmodule

[rtl/stcm_blend.sv]
// two-stage saturation blend: weighted gray, then mix toward gray by vividness
// depends on stcm_pkg
`timescale 1ns / 1ps

module stcm_blend (
  input  logic             clk,
  input  logic             en,
  input  logic [8:0]       vividness,
  input  stcm_pkg::in_item_t item_i,
  output stcm_pkg::in_item_t item_o
);
  import stcm_pkg::*;

  in_item_t   s1_item_r;
  logic [7:0] gray_r;
  in_item_t   s2_item_r;

  logic [15:0] gray_sum;
  logic [8:0]  viv_eff;
  logic [8:0]  inv_viv;
  in_item_t    s2_item_nxt;

  assign gray_sum = 16'(16'(item_i.red_in) * 16'(GRAY_W_RED))
                  + 16'(16'(item_i.green_in) * 16'(GRAY_W_GREEN))
                  + 16'(16'(item_i.blue_in) * 16'(GRAY_W_BLUE));

  // values above full range act as full range
  assign viv_eff = (vividness > FULL_VIVID) ? FULL_VIVID : vividness;
  assign inv_viv = FULL_VIVID - viv_eff;

  function automatic logic [7:0] mix(input logic [7:0] gray, input logic [7:0] chan,
                                     input logic [8:0] inv, input logic [8:0] viv);
    logic [15:0] acc;
    acc = 16'(16'(gray) * 16'(inv)) + 16'(16'(chan) * 16'(viv));
    return acc[15:8];
  endfunction

  always_comb begin
    s2_item_nxt          = s1_item_r;
    s2_item_nxt.red_in   = mix(gray_r, s1_item_r.red_in, inv_viv, viv_eff);
    s2_item_nxt.green_in = mix(gray_r, s1_item_r.green_in, inv_viv, viv_eff);
    s2_item_nxt.blue_in  = mix(gray_r, s1_item_r.blue_in, inv_viv, viv_eff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= item_i;
      gray_r    <= gray_sum[15:8];
      s2_item_r <= s2_item_nxt;
    end
  end

  assign item_o = s2_item_r;

endmodule

[rtl/stcm_lane.sv]
// one color lane of the tone lookup: private per-channel pages, then a shared copy
// depends on stcm_pkg; writes land in each memory at the stage that reads it
`timescale 1ns / 1ps

module stcm_lane #(
  parameter int unsigned LaneIdx = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  stcm_pkg::curve_mode_t  curve_mode,
  input  stcm_pkg::tbl_wr_t      wr,
  input  logic [7:0]             chan_in,
  output logic [7:0]             chan_out
);
  import stcm_pkg::*;

  // page 0 holds region LaneIdx, page 1 holds region LaneIdx+1
  logic [7:0] page_mem [512];
  logic [7:0] shared_mem [256];

  logic [7:0] page_rd_r;
  logic [7:0] chan3_r;
  tbl_wr_t    wr3_r;
  logic [7:0] shared_rd_r;
  logic [7:0] page4_r;
  logic [7:0] chan4_r;

  logic       page_hit;
  logic [8:0] page_wr_idx;
  logic [8:0] page_rd_idx;
  logic [7:0] shared_rd_idx;

  always_comb begin
    page_hit    = 1'b0;
    page_wr_idx = {1'b0, wr.addr[7:0]};
    if (wr.addr[10:8] == 3'(LaneIdx)) begin
      page_hit = wr.en;
    end else if (wr.addr[10:8] == 3'(LaneIdx + 1)) begin
      page_hit    = wr.en;
      page_wr_idx = {1'b1, wr.addr[7:0]};
    end
  end

  assign page_rd_idx   = {curve_mode == CURVE_CHAINED, chan_in};
  assign shared_rd_idx = (curve_mode == CURVE_CHAINED) ? page_rd_r : chan3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (page_hit) begin
        page_mem[page_wr_idx] <= wr.data;
      end
      page_rd_r <= page_mem[page_rd_idx];
      chan3_r   <= chan_in;
      wr3_r     <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr3_r.en && wr3_r.addr[10:8] == 3'd0) begin
        shared_mem[wr3_r.addr[7:0]] <= wr3_r.data;
      end
      shared_rd_r <= shared_mem[shared_rd_idx];
      page4_r     <= page_rd_r;
      chan4_r     <= chan3_r;
    end
  end

  always_comb begin
    case (curve_mode)
      CURVE_NONE:    chan_out = chan4_r;
      CURVE_SHARED:  chan_out = shared_rd_r;
      CURVE_CHANNEL: chan_out = page4_r;
      CURVE_CHAINED: chan_out = shared_rd_r;
      default:       chan_out = chan4_r;
    endcase
  end

endmodule

[rtl/stcm_out_fifo.sv]
// two-entry result buffer between the lookup pipeline and the output channel
// depends on stcm_pkg
`timescale 1ns / 1ps

module stcm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  stcm_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output stcm_pkg::out_item_t out_data
);
  import stcm_pkg::*;

  out_item_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[dv/saturation_tone_curve_mapper_unit_tb.sv]
// self-checking bench for the saturation / tone curve mapper: random and directed pixels
// and tone table writes, predicted in-bench and compared field by field
// depends on rtl/stcm_pkg.sv and rtl/saturation_tone_curve_mapper_unit.sv
`timescale 1ns / 1ps

module saturation_tone_curve_mapper_unit_tb;
  import stcm_pkg::*;

  localparam int TABLE_DEPTH = 1280;
  localparam int PAGE_SIZE   = 256;
  localparam int SETTLE      = 10;
  localparam int LIMIT       = 100000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 88;

  // in-bench model of the mapper: tone table, registers and pixels in flight
  class tone_scoreboard;
    logic [7:0]  tone_bytes [TABLE_DEPTH];
    curve_mode_t mode;
    logic [8:0]  vivid;
    out_item_t   pixel_q [$];
    int          failures;

    function new();
      foreach (tone_bytes[i]) tone_bytes[i] = 8'd0;
      mode     = CURVE_NONE;
      vivid    = FULL_VIVID;
      failures = 0;
    endfunction

    function void set_register(logic [0:0] idx, logic [8:0] value);
      if (idx == CFG_CURVE_MODE) begin
        mode = curve_mode_t'(value[1:0]);
      end else begin
        vivid = value;
      end
    endfunction

    function logic [7:0] map_lane(logic [7:0] v, int lane);
      logic [7:0] mid;
      case (mode)
        CURVE_SHARED: begin
          return tone_bytes[v];
        end
        CURVE_CHANNEL: begin
          return tone_bytes[lane * PAGE_SIZE + v];
        end
        CURVE_CHAINED: begin
          mid = tone_bytes[PAGE_SIZE + lane * PAGE_SIZE + v];
          return tone_bytes[mid];
        end
        default: begin
          return v;
        end
      endcase
    endfunction

    function void note_input(in_item_t it);
      int unsigned r, g, b, gray, inv, v;
      out_item_t   res;
      if (it.operation == OP_TABLE_WRITE) begin
        // writes past the table end are dropped
        if (it.table_address < TABLE_DEPTH) tone_bytes[it.table_address] = it.table_data;
        return;
      end
      r = it.red_in;
      g = it.green_in;
      b = it.blue_in;
      v = (vivid > FULL_VIVID) ? FULL_VIVID : vivid;
      if (v != FULL_VIVID) begin
        gray = (r * GRAY_W_RED + g * GRAY_W_GREEN + b * GRAY_W_BLUE) >> 8;
        inv  = FULL_VIVID - v;
        r    = (gray * inv + r * v) >> 8;
        g    = (gray * inv + g * v) >> 8;
        b    = (gray * inv + b * v) >> 8;
      end
      res.red_out   = map_lane(r[7:0], 0);
      res.green_out = map_lane(g[7:0], 1);
      res.blue_out  = map_lane(b[7:0], 2);
      res.alpha_out = it.alpha_in;
      pixel_q.insert(pixel_q.size(), res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pixel_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                   got.red_out, got.green_out, got.blue_out, got.alpha_out);
        return;
      end
      want = pixel_q.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch mode=%0d vivid=%0d: want r=%0d g=%0d b=%0d a=%0d, ",
                    "got r=%0d g=%0d b=%0d a=%0d"},
                   mode, vivid, want.red_out, want.green_out, want.blue_out, want.alpha_out,
                   got.red_out, got.green_out, got.blue_out, got.alpha_out);
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = CFG_CURVE_MODE;
  logic [8:0] cfg_data  = 9'd0;

  tone_scoreboard sb = new();
  bit  no_idle      = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left    = 0;
  int  cycles       = 0;

  saturation_tone_curve_mapper_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  // result side: random stall, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 120;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 15);
      end
    end
  end

  function automatic logic [7:0] rand_channel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 8'd0;
    if (pick < 20) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation     = ($urandom_range(99) < 30) ? OP_TABLE_WRITE : OP_PIXEL;
    it.table_address = ($urandom_range(99) < 15) ? 11'($urandom_range(2047, 1280))
                                                 : 11'($urandom_range(1279, 0));
    it.table_data    = 8'($urandom);
    it.red_in        = rand_channel();
    it.green_in      = rand_channel();
    it.blue_in       = rand_channel();
    it.alpha_in      = rand_channel();
    return it;
  endfunction

  function automatic in_item_t pixel_item(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a);
    in_item_t it;
    it           = random_item();
    it.operation = OP_PIXEL;
    it.red_in    = r;
    it.green_in  = g;
    it.blue_in   = b;
    it.alpha_in  = a;
    return it;
  endfunction

  function automatic in_item_t table_item(logic [10:0] addr, logic [7:0] value);
    in_item_t it;
    it               = random_item();
    it.operation     = OP_TABLE_WRITE;
    it.table_address = addr;
    it.table_data    = value;
    return it;
  endfunction

  // valid stays high from one item to the next unless an idle cycle is drawn
  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // table writes leave no trace at the output, give them time to land
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  curve_mode_t phase_mode [PHASES] = '{CURVE_CHAINED, CURVE_NONE, CURVE_SHARED, CURVE_CHANNEL,
                                       CURVE_CHAINED, CURVE_SHARED, CURVE_CHANNEL, CURVE_NONE};
  int          phase_vivid [PHASES] = '{256, 0, 511, 170, 1, 256, 85, 257};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no curve yet, so nothing reads the unloaded table
    send_item(pixel_item(8'd0, 8'd0, 8'd0, 8'd0));
    send_item(pixel_item(8'd255, 8'd255, 8'd255, 8'd255));
    send_item(pixel_item(8'hAA, 8'h55, 8'hAA, 8'h55));
    send_item(table_item(11'd2047, 8'hFF));
    send_item(table_item(11'd1280, 8'h5A));
    wait_idle();
    write_reg(CFG_VIVIDNESS, 9'd0);
    send_item(pixel_item(8'd255, 8'd0, 8'd0, 8'd1));
    send_item(pixel_item(8'd0, 8'd255, 8'd0, 8'd2));
    send_item(pixel_item(8'd0, 8'd0, 8'd255, 8'd3));
    send_item(pixel_item(8'd255, 8'd255, 8'd255, 8'd254));
    wait_idle();
    // above full vividness behaves as full
    write_reg(CFG_VIVIDNESS, 9'd511);
    send_item(pixel_item(8'd12, 8'd200, 8'd77, 8'd128));
    wait_idle();
    write_reg(CFG_VIVIDNESS, 9'd257);
    send_item(pixel_item(8'd1, 8'd2, 8'd3, 8'd4));
    wait_idle();
    write_reg(CFG_VIVIDNESS, 9'd255);
    send_item(pixel_item(8'd255, 8'd0, 8'd128, 8'd0));

    // load every table entry before any curve is switched on
    for (int a = 0; a < TABLE_DEPTH; a++) send_item(table_item(11'(a), 8'($urandom)));
    wait_idle();
    write_reg(CFG_CURVE_MODE, 9'(CURVE_SHARED));
    write_reg(CFG_VIVIDNESS, 9'd128);
    send_item(pixel_item(8'd0, 8'd255, 8'd17, 8'd9));
    send_item(pixel_item(8'd255, 8'd0, 8'd255, 8'd0));
    wait_idle();
    write_reg(CFG_CURVE_MODE, 9'(CURVE_CHANNEL));
    send_item(pixel_item(8'd255, 8'd255, 8'd255, 8'd255));
    send_item(pixel_item(8'd0, 8'd0, 8'd0, 8'd0));
    wait_idle();
    write_reg(CFG_CURVE_MODE, 9'(CURVE_CHAINED));
    write_reg(CFG_VIVIDNESS, 9'd0);
    send_item(pixel_item(8'd255, 8'd0, 8'd0, 8'd77));
    send_item(pixel_item(8'd0, 8'd255, 8'd255, 8'd200));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_CURVE_MODE, 9'(phase_mode[p]));
      write_reg(CFG_VIVIDNESS, (p == PHASES - 1) ? 9'($urandom_range(511))
                                                 : 9'(phase_vivid[p]));
      no_idle = (p == 2);
      if (p == 4) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender pauses once mid-phase until the pipeline drains
        if (p == 5 && i == PHASE_ITEMS / 2) wait_idle();
        send_item(random_item());
      end
    end
    no_idle = 1'b0;

    wait_idle();
    sb.failures += sb.pending();
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/stcm_pkg.sv
rtl/stcm_blend.sv
rtl/stcm_lane.sv
rtl/stcm_out_fifo.sv
rtl/saturation_tone_curve_mapper_unit.sv
dv/saturation_tone_curve_mapper_unit_tb.sv
